>>> sv/source_lexer_tokenizer_core_assert.svh
// Assertion macros shared by the lexer modules
`ifndef SOURCE_LEXER_TOKENIZER_CORE_ASSERT_SVH
`define SOURCE_LEXER_TOKENIZER_CORE_ASSERT_SVH

// Concurrent check, disabled in reset
`define SLT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check that also holds in reset
`define SLT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/slt_pkg.sv
package slt_pkg;

  typedef enum logic [3:0] {
    M_IDLE       = 4'd0,
    M_SLASH      = 4'd1,
    M_COMMENT    = 4'd2,
    M_ZERO       = 4'd3,
    M_INT        = 4'd4,
    M_BASED      = 4'd5,
    M_FRAC       = 4'd6,
    M_EXP_START  = 4'd7,
    M_EXP_DIGITS = 4'd8,
    M_IDENT      = 4'd9,
    M_ERROR      = 4'd10
  } scan_mode_t;

  localparam logic [4:0] K_END     = 5'd0;
  localparam logic [4:0] K_COMMENT = 5'd1;
  localparam logic [4:0] K_INTEGER = 5'd2;
  localparam logic [4:0] K_FLOAT   = 5'd3;
  localparam logic [4:0] K_IDENT   = 5'd4;
  localparam logic [4:0] K_KEYWORD0 = 5'd5;
  localparam logic [4:0] K_PUNCT0  = 5'd14;
  localparam logic [4:0] K_SLASH   = 5'd21;
  localparam logic [4:0] K_ERROR   = 5'd28;

  localparam logic [1:0] B_DEC = 2'd0;
  localparam logic [1:0] B_HEX = 2'd1;
  localparam logic [1:0] B_OCT = 2'd2;
  localparam logic [1:0] B_BIN = 2'd3;

  localparam logic [14:0] EXP_LIMIT = 15'd32767;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         kind;
    logic [31:0]        start_pos;
    logic [31:0]        end_pos;
    logic [63:0]        int_value;
    logic [63:0]        frac_value;
    logic [4:0]         frac_digits;
    logic signed [15:0] exponent;
    logic [7:0]         bad_symbol;
    logic               is_last;
  } out_item_t;

  // Up to five identifier bytes with a length; keyword index or ident
  function automatic logic [4:0] keyword_kind(input logic [39:0] b, input logic [2:0] len);
    logic [4:0] k;
    k = K_IDENT;
    priority if (len == 3'd2 && b[15:0] == {"n", "f"}) k = K_KEYWORD0;
    else if (len == 3'd3 && b[23:0] == {"t", "e", "l"}) k = K_KEYWORD0 + 5'd1;
    else if (len == 3'd3 && b[23:0] == {"2", "3", "i"}) k = K_KEYWORD0 + 5'd2;
    else if (len == 3'd3 && b[23:0] == {"2", "3", "u"}) k = K_KEYWORD0 + 5'd3;
    else if (len == 3'd3 && b[23:0] == {"2", "3", "f"}) k = K_KEYWORD0 + 5'd4;
    else if (len == 3'd4 && b[31:0] == {"d", "i", "o", "v"}) k = K_KEYWORD0 + 5'd5;
    else if (len == 3'd2 && b[15:0] == {"f", "i"}) k = K_KEYWORD0 + 5'd6;
    else if (len == 3'd4 && b[31:0] == {"e", "s", "l", "e"}) k = K_KEYWORD0 + 5'd7;
    else if (len == 3'd5 && b == {"e", "l", "i", "h", "w"}) k = K_KEYWORD0 + 5'd8;
    return k;
  endfunction

  // Single-byte punctuator lookup; returns found flag and kind
  function automatic logic [5:0] punct_kind(input logic [7:0] c);
    logic [5:0] r;
    r = '0;
    unique case (c)
      ":": r = {1'b1, K_PUNCT0};
      ";": r = {1'b1, K_PUNCT0 + 5'd1};
      ",": r = {1'b1, K_PUNCT0 + 5'd2};
      "=": r = {1'b1, K_PUNCT0 + 5'd3};
      "+": r = {1'b1, K_PUNCT0 + 5'd4};
      "-": r = {1'b1, K_PUNCT0 + 5'd5};
      "*": r = {1'b1, K_PUNCT0 + 5'd6};
      "/": r = {1'b1, K_PUNCT0 + 5'd7};
      "{": r = {1'b1, K_PUNCT0 + 5'd8};
      "}": r = {1'b1, K_PUNCT0 + 5'd9};
      "(": r = {1'b1, K_PUNCT0 + 5'd10};
      ")": r = {1'b1, K_PUNCT0 + 5'd11};
      "[": r = {1'b1, K_PUNCT0 + 5'd12};
      "]": r = {1'b1, K_PUNCT0 + 5'd13};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/source_lexer_tokenizer_core.sv
// A byte's tokens are written into the output queue when the byte is accepted.
// Throughput: one byte per cycle while the output drains each token at once;
// a byte that ends one token and forms another stalls input until the
// three-entry output queue holds at most one entry again.
// Reset: synchronous, clears scan state, position and the output queue.
module source_lexer_tokenizer_core
  import slt_pkg::*;
#(
  parameter int POS_BITS        = 32,
  parameter int MAX_FRAC_DIGITS = 19
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);
  `include "source_lexer_tokenizer_core_assert.svh"

  localparam logic [4:0] FRAC_MAX = 5'(MAX_FRAC_DIGITS);

  scan_mode_t       mode, mode_next;
  logic [POS_BITS-1:0] position, token_start, token_start_next;
  logic [63:0]      int_accum, int_next, frac_accum, frac_next;
  logic [1:0]       base, base_next;
  logic [4:0]       frac_count, frac_count_next;
  logic [14:0]      exp_mag, exp_mag_next;
  logic             exp_neg, exp_neg_next;
  logic [7:0]       ident_bytes [5];
  logic [2:0]       ident_len, ident_len_next;
  logic             idw_en;
  logic [2:0]       idw_idx;

  logic      accept, space2;
  logic [1:0] n_tok;
  out_item_t tok0, tok1, pend, newt;
  logic      have_pend, have_new;

  logic [7:0] c;
  logic is_dec, is_alpha, is_word, is_space, consumed;
  logic [4:0] dval;
  logic [5:0] pk;
  logic [POS_BITS-1:0] pos_inc, tstart_inc;
  logic [19:0] exp_prod;

  assign accept   = in_valid && !in_stall;
  assign in_stall = !space2;
  assign c        = in_data.ch;
  assign is_dec   = c >= "0" && c <= "9";
  assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign is_word  = is_alpha || is_dec || c == "_";
  assign is_space = c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  assign pos_inc  = position + 1'b1;
  assign tstart_inc = token_start + 1'b1;
  assign pk       = punct_kind(c);
  assign exp_prod = {5'd0, exp_mag} * 20'd10 + {16'd0, c[3:0]};

  // Digit value with hex letters; 16 marks no digit
  always_comb begin
    if (is_dec) dval = {1'b0, c[3:0]};
    else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) dval = 5'(c[2:0]) + 5'd9;
    else dval = 5'd16;
  end

  // Pending token, built from current state
  always_comb begin
    logic is_float;
    logic [39:0] idb;
    idb = {ident_bytes[4], ident_bytes[3], ident_bytes[2], ident_bytes[1], ident_bytes[0]};
    is_float = mode == M_FRAC || mode == M_EXP_START || mode == M_EXP_DIGITS;
    pend = '0;
    pend.start_pos = 32'(token_start);
    pend.end_pos   = 32'(position);
    have_pend = 1'b1;
    unique case (mode)
      M_SLASH: begin
        pend.kind = K_SLASH;
        pend.end_pos = 32'(tstart_inc);
      end
      M_COMMENT: pend.kind = K_COMMENT;
      M_ZERO, M_INT, M_BASED, M_FRAC, M_EXP_START, M_EXP_DIGITS: begin
        pend.kind = is_float ? K_FLOAT : K_INTEGER;
        pend.int_value = int_accum;
        if (is_float) begin
          pend.frac_value  = frac_accum;
          pend.frac_digits = frac_count;
          pend.exponent    = exp_neg ? -$signed({1'b0, exp_mag}) : $signed({1'b0, exp_mag});
        end
      end
      M_IDENT: pend.kind = ident_len <= 3'd5 ? keyword_kind(idb, ident_len) : K_IDENT;
      default: have_pend = 1'b0;
    endcase
  end

  // Next state and tokens for the accepted byte
  always_comb begin
    logic [63:0] bmul;
    mode_next = mode;
    token_start_next = token_start;
    int_next = int_accum;
    frac_next = frac_accum;
    base_next = base;
    frac_count_next = frac_count;
    exp_mag_next = exp_mag;
    exp_neg_next = exp_neg;
    ident_len_next = ident_len;
    idw_en = 1'b0;
    idw_idx = ident_len;
    consumed = 1'b0;
    have_new = 1'b0;
    newt = '0;
    newt.start_pos = 32'(position);
    newt.end_pos   = 32'(pos_inc);
    unique case (base)
      B_HEX:   bmul = {int_accum[59:0], 4'd0};
      B_OCT:   bmul = {int_accum[60:0], 3'd0};
      B_BIN:   bmul = {int_accum[62:0], 1'b0};
      default: bmul = {int_accum[60:0], 3'd0} + {int_accum[62:0], 1'b0};
    endcase
    // Try to extend the pending token
    unique case (mode)
      M_SLASH: if (c == "/") begin
        consumed = 1'b1; mode_next = M_COMMENT; token_start_next = pos_inc;
      end
      M_COMMENT: begin
        consumed = 1'b1;
        if (c == 8'd10) begin
          have_new = 1'b1;
          newt.kind = K_COMMENT;
          newt.start_pos = 32'(token_start);
          newt.end_pos = 32'(position);
          mode_next = M_IDLE;
        end
      end
      M_ZERO, M_INT: begin
        if (mode == M_ZERO && (c == "x" || c == "o" || c == "b")) begin
          consumed = 1'b1; mode_next = M_BASED;
          base_next = c == "x" ? B_HEX : (c == "o" ? B_OCT : B_BIN);
        end else if (is_dec) begin
          consumed = 1'b1; mode_next = M_INT;
          int_next = {int_accum[60:0], 3'd0} + {int_accum[62:0], 1'b0} + 64'(c[3:0]);
        end else if (c == ".") begin
          consumed = 1'b1; mode_next = M_FRAC;
        end else if (c == "e") begin
          consumed = 1'b1; mode_next = M_EXP_START;
        end
      end
      M_BASED: begin
        if ((base == B_HEX && dval < 5'd16) || (base == B_OCT && dval < 5'd8) ||
            (base == B_BIN && dval < 5'd2) || (base == B_DEC && dval < 5'd10)) begin
          consumed = 1'b1; int_next = bmul + 64'(dval);
        end
      end
      M_FRAC: begin
        if (is_dec) begin
          consumed = 1'b1;
          if (frac_count < FRAC_MAX) begin
            frac_next = {frac_accum[60:0], 3'd0} + {frac_accum[62:0], 1'b0} + 64'(c[3:0]);
            frac_count_next = frac_count + 5'd1;
          end
        end else if (c == "e") begin
          consumed = 1'b1; mode_next = M_EXP_START;
        end
      end
      M_EXP_START, M_EXP_DIGITS: begin
        if (mode == M_EXP_START && (c == "+" || c == "-")) begin
          consumed = 1'b1; exp_neg_next = c == "-"; mode_next = M_EXP_DIGITS;
        end else if (is_dec) begin
          consumed = 1'b1; mode_next = M_EXP_DIGITS;
          exp_mag_next = exp_prod > 20'(EXP_LIMIT) ? EXP_LIMIT : exp_prod[14:0];
        end
      end
      M_IDENT: if (is_word) begin
        consumed = 1'b1;
        idw_en = ident_len < 3'd5;
        if (ident_len < 3'd6) ident_len_next = ident_len + 3'd1;
      end
      M_ERROR: consumed = 1'b1;
      default: consumed = 1'b0;
    endcase
    // Not consumed: start a new token
    if (!consumed) begin
      mode_next = M_IDLE;
      if (!is_space) begin
        token_start_next = position;
        if (c == "/") begin
          mode_next = M_SLASH;
        end else if (is_dec) begin
          int_next = 64'(c[3:0]);
          base_next = B_DEC;
          frac_next = '0; frac_count_next = '0; exp_mag_next = '0; exp_neg_next = 1'b0;
          mode_next = c == "0" ? M_ZERO : M_INT;
        end else if (pk[5]) begin
          have_new = 1'b1; newt.kind = pk[4:0];
        end else if (is_alpha || c == "_") begin
          idw_en = 1'b1; idw_idx = 3'd0; ident_len_next = 3'd1; mode_next = M_IDENT;
        end else begin
          have_new = 1'b1; newt.kind = K_ERROR; newt.bad_symbol = c; mode_next = M_ERROR;
        end
      end
    end
  end

  // Token ordering into the output queue
  always_comb begin
    logic flush_p, new_p;
    out_item_t nt;
    tok0 = '0; tok1 = '0; n_tok = 2'd0;
    nt = newt;
    if (in_data.end_of_input) begin
      flush_p = have_pend;
      new_p = 1'b1;
    end else begin
      flush_p = !consumed && have_pend;
      new_p = have_new;
    end
    if (in_data.end_of_input) begin
      nt = '0;
      nt.kind = K_END;
      nt.start_pos = 32'(position);
      nt.end_pos = 32'(position);
    end
    if (flush_p) begin
      tok0 = pend;
      tok1 = nt;
      tok1.is_last = 1'b1;
      tok0.is_last = !new_p;
      n_tok = new_p ? 2'd2 : 2'd1;
    end else if (new_p) begin
      tok0 = nt; tok0.is_last = 1'b1; n_tok = 2'd1;
    end
    if (!accept) n_tok = 2'd0;
  end

  // Identifier byte store, written only where it is later read
  always_ff @(posedge clk) begin
    if (accept && !in_data.end_of_input && idw_en) ident_bytes[idw_idx] <= c;
  end

  // Scan state
  always_ff @(posedge clk) begin
    if (rst || (accept && in_data.end_of_input)) begin
      mode <= M_IDLE; position <= '0; token_start <= '0; int_accum <= '0;
      base <= B_DEC; frac_accum <= '0; frac_count <= '0; exp_mag <= '0;
      exp_neg <= 1'b0; ident_len <= '0;
    end else if (accept) begin
      mode <= mode_next; position <= pos_inc; token_start <= token_start_next;
      int_accum <= int_next; base <= base_next; frac_accum <= frac_next;
      frac_count <= frac_count_next; exp_mag <= exp_mag_next; exp_neg <= exp_neg_next;
      ident_len <= ident_len_next;
    end
  end

  slt_out_queue u_queue (
    .clk(clk), .rst(rst), .push_count(n_tok), .push0(tok0), .push1(tok1),
    .space2(space2), .valid(out_valid), .stall(out_stall), .item(out_data)
  );

  `SLT_ASSERT(a_error_sticky, !$past(rst) && $past(mode) == M_ERROR && !$past(accept && in_data.end_of_input) |-> mode == M_ERROR, "error mode left early")
  `SLT_ASSERT(a_frac_bound, frac_count <= FRAC_MAX, "fraction count overrun")
  `SLT_ASSERT(a_exp_bound, exp_mag <= EXP_LIMIT, "exponent over limit")

endmodule

>>> sv/slt_out_queue.sv
// Three-entry output queue: takes up to two tokens per cycle, drains one.
module slt_out_queue
  import slt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic [1:0] push_count,
  input  out_item_t push0,
  input  out_item_t push1,
  output logic      space2,
  output logic      valid,
  input  logic      stall,
  output out_item_t item
);
  `include "source_lexer_tokenizer_core_assert.svh"

  out_item_t ent0, ent1, ent2;
  logic [1:0] cnt, cnt_next;
  logic pop;

  assign pop   = (cnt != 2'd0) && !stall;
  assign valid = cnt != 2'd0;
  assign item  = ent0;
  // Accept a new item only if two of the three slots are free now
  assign space2 = cnt <= 2'd1;

  always_comb begin
    cnt_next = cnt - {1'b0, pop} + push_count;
  end

  // Shift out on pop, then append pushes behind the remaining entries
  always_ff @(posedge clk) begin
    out_item_t a0, a1;
    a0 = pop ? ent1 : ent0;
    a1 = pop ? ent2 : ent1;
    ent0 <= a0;
    ent1 <= a1;
    ent2 <= ent2;
    unique case (cnt - {1'b0, pop})
      2'd0: begin
        ent0 <= push0;
        ent1 <= push1;
      end
      2'd1: begin
        ent1 <= push0;
        ent2 <= push1;
      end
      2'd2: begin
        ent2 <= push0;
      end
      default: begin
      end
    endcase
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  `SLT_ASSERT(a_no_overflow, push_count == 2'd0 || cnt <= 2'd1, "output queue overflow")
  `SLT_ASSERT(a_push_two_last, push_count != 2'd2 || (!push0.is_last && push1.is_last), "is_last misplaced")
  `SLT_ASSERT(a_hold_stalled, $past(valid && stall) |-> valid && item == $past(item), "stalled output changed")

endmodule

>>> tb/source_lexer_tokenizer_checker.sv
module source_lexer_tokenizer_checker
  import slt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        tokens_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_KEEP = 19;
  localparam string PUNCT_SET = ":;,=+-*/{}()[]";

  string keyword_names[9] = '{"fn", "let", "i32", "u32", "f32", "void", "if", "else", "while"};

  // Lexer state mirror
  scan_mode_t  mode;
  logic [31:0] pos;
  logic [31:0] tok_start;
  logic [63:0] int_acc;
  logic [1:0]  radix;
  logic [63:0] frac_acc;
  logic [4:0]  frac_cnt;
  int          exp_mag;
  logic        exp_neg;
  logic [7:0]  word_bytes [5];
  logic [2:0]  word_len;

  out_item_t   step_tokens [2];
  int          step_count;
  out_item_t   token_q [$];

  initial fail_count = 0;
  initial tokens_pending = 0;

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t: token mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
    fail_count++;
  endtask

  task automatic clear_state();
    mode = M_IDLE;
    pos = '0;
    tok_start = '0;
    int_acc = '0;
    radix = B_DEC;
    frac_acc = '0;
    frac_cnt = '0;
    exp_mag = 0;
    exp_neg = 1'b0;
    word_len = '0;
  endtask

  task automatic add_token(logic [4:0] k, logic [31:0] s, logic [31:0] e,
                           logic [63:0] iv = '0, logic [63:0] fv = '0,
                           logic [4:0] fc = '0, logic [15:0] ex = '0,
                           logic [7:0] bad = '0);
    out_item_t t;
    if (step_count < 2) begin
      t.kind = k;
      t.start_pos = s;
      t.end_pos = e;
      t.int_value = iv;
      t.frac_value = fv;
      t.frac_digits = fc;
      t.exponent = ex;
      t.bad_symbol = bad;
      t.is_last = 1'b0;
      step_tokens[step_count] = t;
      step_count++;
    end
  endtask

  function automatic logic [4:0] word_kind();
    string w;
    w = "";
    if (word_len > 3'd5) return K_IDENT;
    for (int i = 0; i < word_len; i++) w = {w, string'(word_bytes[i])};
    for (int i = 0; i < 9; i++) begin
      if (w == keyword_names[i]) return K_KEYWORD0 + 5'(i);
    end
    return K_IDENT;
  endfunction

  function automatic int digit_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return 16;
  endfunction

  function automatic bit is_dec(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // Close whatever lexeme is open
  task automatic flush_token();
    logic [15:0] ex;
    ex = exp_neg ? -16'(exp_mag) : 16'(exp_mag);
    case (mode)
      M_SLASH: add_token(K_SLASH, tok_start, tok_start + 32'd1);
      M_COMMENT: add_token(K_COMMENT, tok_start, pos);
      M_ZERO, M_INT, M_BASED: add_token(K_INTEGER, tok_start, pos, int_acc);
      M_FRAC, M_EXP_START, M_EXP_DIGITS:
        add_token(K_FLOAT, tok_start, pos, int_acc, frac_acc, frac_cnt, ex);
      M_IDENT: add_token(word_kind(), tok_start, pos);
      default: ;
    endcase
    if (mode != M_ERROR) mode = M_IDLE;
  endtask

  task automatic add_exp_digit(logic [7:0] c);
    int v;
    v = exp_mag * 10 + (c - "0");
    exp_mag = v > int'(EXP_LIMIT) ? int'(EXP_LIMIT) : v;
    mode = M_EXP_DIGITS;
  endtask

  // Try to grow the open lexeme with c
  task automatic grow(logic [7:0] c, output bit took);
    int d;
    int b;
    took = 1'b0;
    case (mode)
      M_SLASH: begin
        if (c == "/") begin
          mode = M_COMMENT;
          tok_start = pos + 32'd1;
          took = 1'b1;
        end
      end
      M_COMMENT: begin
        if (c == 8'h0a) begin
          add_token(K_COMMENT, tok_start, pos);
          mode = M_IDLE;
        end
        took = 1'b1;
      end
      M_ZERO, M_INT: begin
        if (mode == M_ZERO && (c == "x" || c == "o" || c == "b")) begin
          radix = c == "x" ? B_HEX : (c == "o" ? B_OCT : B_BIN);
          mode = M_BASED;
          took = 1'b1;
        end else if (is_dec(c)) begin
          int_acc = int_acc * 64'd10 + 64'(c - "0");
          mode = M_INT;
          took = 1'b1;
        end else if (c == ".") begin
          mode = M_FRAC;
          took = 1'b1;
        end else if (c == "e") begin
          mode = M_EXP_START;
          took = 1'b1;
        end
      end
      M_BASED: begin
        b = radix == B_HEX ? 16 : (radix == B_OCT ? 8 : (radix == B_BIN ? 2 : 10));
        d = digit_of(c);
        if (d < b) begin
          int_acc = int_acc * 64'(b) + 64'(d);
          took = 1'b1;
        end
      end
      M_FRAC: begin
        if (is_dec(c)) begin
          if (frac_cnt < FRAC_KEEP) begin
            frac_acc = frac_acc * 64'd10 + 64'(c - "0");
            frac_cnt++;
          end
          took = 1'b1;
        end else if (c == "e") begin
          mode = M_EXP_START;
          took = 1'b1;
        end
      end
      M_EXP_START: begin
        if (c == "+" || c == "-") begin
          exp_neg = c == "-";
          mode = M_EXP_DIGITS;
          took = 1'b1;
        end else if (is_dec(c)) begin
          add_exp_digit(c);
          took = 1'b1;
        end
      end
      M_EXP_DIGITS: begin
        if (is_dec(c)) begin
          add_exp_digit(c);
          took = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_alpha(c) || is_dec(c) || c == "_") begin
          if (word_len < 3'd5) word_bytes[word_len] = c;
          if (word_len < 3'd6) word_len++;
          took = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // Open a new lexeme from c
  task automatic open_token(logic [7:0] c);
    if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) return;
    tok_start = pos;
    if (c == "/") begin
      mode = M_SLASH;
      return;
    end
    if (is_dec(c)) begin
      int_acc = 64'(c - "0");
      radix = B_DEC;
      frac_acc = '0;
      frac_cnt = '0;
      exp_mag = 0;
      exp_neg = 1'b0;
      mode = c == "0" ? M_ZERO : M_INT;
      return;
    end
    for (int i = 0; i < 14; i++) begin
      if (PUNCT_SET[i] == c) begin
        add_token(K_PUNCT0 + 5'(i), pos, pos + 32'd1);
        return;
      end
    end
    if (is_alpha(c) || c == "_") begin
      word_bytes[0] = c;
      word_len = 3'd1;
      mode = M_IDENT;
      return;
    end
    add_token(K_ERROR, pos, pos + 32'd1, '0, '0, '0, '0, c);
    mode = M_ERROR;
  endtask

  // Work out the tokens of one accepted transaction
  task automatic lex_step(in_item_t it);
    bit took;
    step_count = 0;
    if (it.end_of_input) begin
      flush_token();
      add_token(K_END, pos, pos);
      clear_state();
    end else begin
      if (mode != M_ERROR) begin
        grow(it.ch, took);
        if (!took) begin
          flush_token();
          open_token(it.ch);
        end
      end
      pos++;
    end
    if (step_count > 0) step_tokens[step_count - 1].is_last = 1'b1;
    for (int i = 0; i < step_count; i++) token_q.push_back(step_tokens[i]);
  endtask

  // Watch both channels
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      clear_state();
      token_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (token_q.size() == 0) begin
          report("kind (none expected)", 64'(out_data.kind), '0);
        end else begin
          want = token_q.pop_front();
          if (out_data.kind !== want.kind) report("kind", out_data.kind, want.kind);
          if (out_data.start_pos !== want.start_pos)
            report("start_pos", out_data.start_pos, want.start_pos);
          if (out_data.end_pos !== want.end_pos)
            report("end_pos", out_data.end_pos, want.end_pos);
          if (out_data.int_value !== want.int_value)
            report("int_value", out_data.int_value, want.int_value);
          if (out_data.frac_value !== want.frac_value)
            report("frac_value", out_data.frac_value, want.frac_value);
          if (out_data.frac_digits !== want.frac_digits)
            report("frac_digits", out_data.frac_digits, want.frac_digits);
          if (out_data.exponent !== want.exponent)
            report("exponent", 64'(out_data.exponent), 64'(want.exponent));
          if (out_data.bad_symbol !== want.bad_symbol)
            report("bad_symbol", out_data.bad_symbol, want.bad_symbol);
          if (out_data.is_last !== want.is_last)
            report("is_last", out_data.is_last, want.is_last);
        end
      end
      if (in_valid && !in_stall) lex_step(in_data);
    end
    tokens_pending = token_q.size();
  end

endmodule

>>> tb/tb_source_lexer_tokenizer_core.sv
module tb_source_lexer_tokenizer_core;
  import slt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BYTE_TARGET = 1750;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        tokens_pending;
  bit        calm = 1'b0;
  in_item_t  src_q [$];

  string keyword_names[9] = '{"fn", "let", "i32", "u32", "f32", "void", "if", "else", "while"};

  source_lexer_tokenizer_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  source_lexer_tokenizer_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .tokens_pending(tokens_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= !rst && !calm && ($urandom_range(0, 99) < 17);
  end

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back('{ch: s[i], end_of_input: 1'b0});
  endtask

  task automatic put_byte(logic [7:0] c);
    src_q.push_back('{ch: c, end_of_input: 1'b0});
  endtask

  task automatic put_end();
    src_q.push_back('{ch: 8'($urandom_range(0, 255)), end_of_input: 1'b1});
  endtask

  task automatic put_digits(int n, string set);
    for (int i = 0; i < n; i++) put_byte(set[$urandom_range(0, set.len() - 1)]);
  endtask

  // One random lexeme, mostly well formed
  task automatic put_lexeme();
    int pick;
    string word_set;
    word_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    pick = $urandom_range(0, 99);
    if (pick < 14) put_text(keyword_names[$urandom_range(0, 8)]);
    else if (pick < 26) begin
      put_digits(1, word_set.substr(0, 52));
      put_digits($urandom_range(0, 7), word_set);
    end else if (pick < 38) put_digits($urandom_range(1, 22), "0123456789");
    else if (pick < 50) begin
      put_byte("0");
      case ($urandom_range(0, 2))
        0: begin
          put_byte("x");
          put_digits($urandom_range(0, 18), "0123456789abcdefABCDEF");
        end
        1: begin
          put_byte("o");
          put_digits($urandom_range(0, 23), "01234567");
        end
        default: begin
          put_byte("b");
          put_digits($urandom_range(0, 66), "01");
        end
      endcase
    end else if (pick < 64) begin
      put_digits($urandom_range(1, 4), "0123456789");
      if ($urandom_range(0, 3) != 0) begin
        put_byte(".");
        put_digits($urandom_range(0, 24), "0123456789");
      end
      if ($urandom_range(0, 2) != 0) begin
        put_byte("e");
        if ($urandom_range(0, 1)) put_byte($urandom_range(0, 1) ? "+" : "-");
        put_digits($urandom_range(0, 7), "0123456789");
      end
    end else if (pick < 70) begin
      put_text("//");
      for (int i = $urandom_range(0, 10); i > 0; i--) put_byte(8'($urandom_range(11, 255)));
      put_byte(8'h0a);
    end else if (pick < 84) put_digits(1, ":;,=+-*/{}()[]");
    else if (pick < 93) put_digits($urandom_range(1, 3), " \t\n\r");
    else if (pick < 96) put_byte(8'($urandom_range(0, 255)));
    else put_end();
    // adjacency lets one byte close a token and open another
    if ($urandom_range(0, 2) == 0) put_byte(" ");
  endtask

  // Stimulus
  initial begin
    bit st;
    put_text("fn let i32 u32 f32 void if else while whilex _a9 ");
    put_text("0x1Ff 0o178 0b1012 0x 0o 0b 0xg 1.5e-7 1e 2e+ 9. ");
    put_text("18446744073709551617 0.12345678901234567890123 1e99999 ");
    put_text("// note\n/ a/b : ;,=+-*{}()[] 3.e5x ");
    put_end();
    put_text("ab 7/");
    put_end();
    put_text("//tail");
    put_end();
    put_text("a # b ");
    put_byte(8'hff);
    put_end();
    put_byte(8'h00);
    put_end();
    while (src_q.size() < BYTE_TARGET) put_lexeme();
    put_end();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < src_q.size(); n++) begin
      calm = n >= 800 && n < 1100;
      while (!calm && $urandom_range(0, 99) < 17) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= src_q[n];
      forever begin
        @(negedge clk);
        st = in_stall;
        @(posedge clk);
        if (!st) break;
      end
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    @(negedge clk);
    wait (tokens_pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/slt_pkg.sv
sv/slt_out_queue.sv
sv/source_lexer_tokenizer_core.sv
tb/source_lexer_tokenizer_checker.sv
tb/tb_source_lexer_tokenizer_core.sv
